>>> rtl/circle_quad_collision_defines.svh
// ----------------------------------------------------------------------------
// circle_quad_collision_defines
// Assertion macros shared by the collision pipeline; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_QUAD_COLLISION_DEFINES_SVH
`define CIRCLE_QUAD_COLLISION_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define CQC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("cqc assertion failed");
// checked on every clock edge, reset included
`define CQC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("cqc assertion failed");
`else
`define CQC_ASSERT(lbl, prop)
`define CQC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/cqc_pkg.sv
// ----------------------------------------------------------------------------
// cqc_pkg
// Widths, edge tables and stage payload types of the collision pipeline.
// ----------------------------------------------------------------------------
package cqc_pkg;

  // coordinate format, signed Q11.4
  localparam int COORD_BITS = 16;
  localparam int RAD_W      = COORD_BITS - 1;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int LEN_W      = PROD_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int R2_W       = 2 * RAD_W;
  localparam int HALF_W     = LEN_W / 2;
  localparam int RP_W       = R2_W + HALF_W;
  localparam int SQ_W       = 2 * LEN_W;

  // box edges walked as 0-1, 1-3, 3-2, 2-0
  localparam logic [3:0][1:0] EDGE_FROM = {2'd2, 2'd3, 2'd1, 2'd0};
  localparam logic [3:0][1:0] EDGE_TO   = {2'd0, 2'd2, 2'd3, 2'd1};

  typedef struct packed {
    logic [COORD_BITS-1:0]       ball_x;
    logic [COORD_BITS-1:0]       ball_y;
    logic [RAD_W-1:0]            ball_radius;
    logic [3:0][COORD_BITS-1:0]  corner_x;
    logic [3:0][COORD_BITS-1:0]  corner_y;
  } req_t;

  typedef struct packed {
    logic [3:0][DIFF_W-1:0] dx;
    logic [3:0][DIFF_W-1:0] dy;
    logic [3:0][DIFF_W-1:0] qx;
    logic [3:0][DIFF_W-1:0] qy;
    logic [3:0][DIFF_W-1:0] mx;
    logic [3:0][DIFF_W-1:0] my;
    logic [RAD_W-1:0]       rad;
  } diff_t;

  typedef struct packed {
    logic [3:0][PROD_W-1:0] dx2;
    logic [3:0][PROD_W-1:0] dy2;
    logic [3:0][PROD_W-1:0] qx2;
    logic [3:0][PROD_W-1:0] qy2;
    logic [3:0][PROD_W-1:0] dot_x;
    logic [3:0][PROD_W-1:0] dot_y;
    logic [3:0][PROD_W-1:0] crs_a;
    logic [3:0][PROD_W-1:0] crs_b;
    logic [R2_W-1:0]        r2;
  } prod_t;

  typedef struct packed {
    logic                  corner;
    logic [3:0]            proj_ok;
    logic [3:0][LEN_W-1:0] pq2;
    logic [3:0][LEN_W-1:0] crs_mag;
    logic [R2_W-1:0]       r2;
  } sum_t;

  typedef struct packed {
    logic                     corner;
    logic [3:0]               proj_ok;
    logic [3:0][2*HALF_W-1:0] sq_hh;
    logic [3:0][2*HALF_W-1:0] sq_hl;
    logic [3:0][2*HALF_W-1:0] sq_ll;
    logic [3:0][RP_W-1:0]     rp_h;
    logic [3:0][RP_W-1:0]     rp_l;
  } part_t;

  typedef struct packed {
    logic hit;
    logic corner_hit;
    logic edge_hit;
  } res_t;

endpackage

>>> rtl/circle_quad_collision.sv
// ----------------------------------------------------------------------------
// circle_quad_collision
// Circle versus four-cornered box overlap test, five-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one request per cycle while req_stall is low and returns one result
// per request, in order. The five register stages are offsets, products, sums
// and projection window, partial products of the 34-bit squaring, then the
// final recombine and compare. Each stage holds its item only while the stage
// after it is full and stalled, so bubbles close up and a stalled result never
// blocks intake until the pipeline is full. Coordinates are signed Q11.4, the
// radius unsigned Q11.4; all tests are strict, so a zero radius never hits,
// and an edge of zero length never hits the edge test.
`include "circle_quad_collision_defines.svh"

module circle_quad_collision (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [cqc_pkg::COORD_BITS-1:0]  ball_x,
  input  logic [cqc_pkg::COORD_BITS-1:0]  ball_y,
  input  logic [cqc_pkg::RAD_W-1:0]       ball_radius,
  input  logic [cqc_pkg::COORD_BITS-1:0]  corner0_x,
  input  logic [cqc_pkg::COORD_BITS-1:0]  corner0_y,
  input  logic [cqc_pkg::COORD_BITS-1:0]  corner1_x,
  input  logic [cqc_pkg::COORD_BITS-1:0]  corner1_y,
  input  logic [cqc_pkg::COORD_BITS-1:0]  corner2_x,
  input  logic [cqc_pkg::COORD_BITS-1:0]  corner2_y,
  input  logic [cqc_pkg::COORD_BITS-1:0]  corner3_x,
  input  logic [cqc_pkg::COORD_BITS-1:0]  corner3_y,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic                            hit,
  output logic                            corner_hit,
  output logic                            edge_hit
);
  import cqc_pkg::*;

  req_t  req;
  diff_t s1_data;
  prod_t s2_data;
  sum_t  s3_data;
  part_t s4_data;
  res_t  res;
  logic  s1_valid, s2_valid, s3_valid, s4_valid;
  logic  s1_stall, s2_stall, s3_stall, s4_stall;

  // gather the request fields
  assign req.ball_x      = ball_x;
  assign req.ball_y      = ball_y;
  assign req.ball_radius = ball_radius;
  assign req.corner_x    = {corner3_x, corner2_x, corner1_x, corner0_x};
  assign req.corner_y    = {corner3_y, corner2_y, corner1_y, corner0_y};

  cqc_diff u_diff (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_stall (req_stall),
    .up_data  (req),
    .dn_valid (s1_valid),
    .dn_stall (s1_stall),
    .dn_data  (s1_data)
  );

  cqc_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_stall (s1_stall),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_stall (s2_stall),
    .dn_data  (s2_data)
  );

  cqc_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s2_valid),
    .up_stall (s2_stall),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_stall (s3_stall),
    .dn_data  (s3_data)
  );

  cqc_part u_part (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s3_valid),
    .up_stall (s3_stall),
    .up_data  (s3_data),
    .dn_valid (s4_valid),
    .dn_stall (s4_stall),
    .dn_data  (s4_data)
  );

  cqc_cmp u_cmp (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s4_valid),
    .up_stall (s4_stall),
    .up_data  (s4_data),
    .dn_valid (rsp_valid),
    .dn_stall (rsp_stall),
    .dn_data  (res)
  );

  // result fields
  assign hit        = res.hit;
  assign corner_hit = res.corner_hit;
  assign edge_hit   = res.edge_hit;

  // reset empties the whole pipeline, every stage together
  `CQC_ASSERT_ALWAYS(a_top_reset_empty, rst |=> (!rsp_valid && !s1_valid && !s2_valid && !s3_valid && !s4_valid))

endmodule

>>> rtl/cqc_diff.sv
// ----------------------------------------------------------------------------
// cqc_diff
// First stage: corner offsets from the center, edge vectors and offsets.
// ----------------------------------------------------------------------------
module cqc_diff (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_stall,
  input  cqc_pkg::req_t up_data,
  output logic          dn_valid,
  input  logic          dn_stall,
  output cqc_pkg::diff_t dn_data
);
  import cqc_pkg::*;

  diff_t dn_data_next;
  logic  stall_here;

  // differences, sign extended by one bit so nothing wraps
  always_comb begin
    dn_data_next = '0;
    for (int k = 0; k < 4; k++) begin
      dn_data_next.dx[k] = DIFF_W'($signed(up_data.corner_x[k])) -
                           DIFF_W'($signed(up_data.ball_x));
      dn_data_next.dy[k] = DIFF_W'($signed(up_data.corner_y[k])) -
                           DIFF_W'($signed(up_data.ball_y));
      dn_data_next.qx[k] = DIFF_W'($signed(up_data.corner_x[EDGE_TO[k]])) -
                           DIFF_W'($signed(up_data.corner_x[EDGE_FROM[k]]));
      dn_data_next.qy[k] = DIFF_W'($signed(up_data.corner_y[EDGE_TO[k]])) -
                           DIFF_W'($signed(up_data.corner_y[EDGE_FROM[k]]));
      dn_data_next.mx[k] = DIFF_W'($signed(up_data.ball_x)) -
                           DIFF_W'($signed(up_data.corner_x[EDGE_FROM[k]]));
      dn_data_next.my[k] = DIFF_W'($signed(up_data.ball_y)) -
                           DIFF_W'($signed(up_data.corner_y[EDGE_FROM[k]]));
    end
    dn_data_next.rad = up_data.ball_radius;
  end

  // stage register, holds while the next stage stalls
  assign stall_here = dn_valid && dn_stall;
  assign up_stall   = stall_here;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!stall_here) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_here && up_valid) begin
      dn_data <= dn_data_next;
    end
  end

endmodule

>>> rtl/cqc_mult.sv
// ----------------------------------------------------------------------------
// cqc_mult
// Second stage: all squares, dot and cross product terms, radius squared.
// ----------------------------------------------------------------------------
module cqc_mult (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_stall,
  input  cqc_pkg::diff_t up_data,
  output logic           dn_valid,
  input  logic           dn_stall,
  output cqc_pkg::prod_t dn_data
);
  import cqc_pkg::*;

  prod_t dn_data_next;
  logic  stall_here;

  // one 17x17 signed product per term
  always_comb begin
    logic signed [PROD_W-1:0] p_dx2, p_dy2, p_qx2, p_qy2;
    logic signed [PROD_W-1:0] p_dotx, p_doty, p_crsa, p_crsb;
    dn_data_next = '0;
    for (int k = 0; k < 4; k++) begin
      p_dx2  = PROD_W'($signed(up_data.dx[k])) * PROD_W'($signed(up_data.dx[k]));
      p_dy2  = PROD_W'($signed(up_data.dy[k])) * PROD_W'($signed(up_data.dy[k]));
      p_qx2  = PROD_W'($signed(up_data.qx[k])) * PROD_W'($signed(up_data.qx[k]));
      p_qy2  = PROD_W'($signed(up_data.qy[k])) * PROD_W'($signed(up_data.qy[k]));
      p_dotx = PROD_W'($signed(up_data.qx[k])) * PROD_W'($signed(up_data.mx[k]));
      p_doty = PROD_W'($signed(up_data.qy[k])) * PROD_W'($signed(up_data.my[k]));
      p_crsa = PROD_W'($signed(up_data.qx[k])) * PROD_W'($signed(up_data.my[k]));
      p_crsb = PROD_W'($signed(up_data.qy[k])) * PROD_W'($signed(up_data.mx[k]));
      dn_data_next.dx2[k]   = p_dx2;
      dn_data_next.dy2[k]   = p_dy2;
      dn_data_next.qx2[k]   = p_qx2;
      dn_data_next.qy2[k]   = p_qy2;
      dn_data_next.dot_x[k] = p_dotx;
      dn_data_next.dot_y[k] = p_doty;
      dn_data_next.crs_a[k] = p_crsa;
      dn_data_next.crs_b[k] = p_crsb;
    end
    dn_data_next.r2 = R2_W'(up_data.rad) * R2_W'(up_data.rad);
  end

  // stage register
  assign stall_here = dn_valid && dn_stall;
  assign up_stall   = stall_here;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!stall_here) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_here && up_valid) begin
      dn_data <= dn_data_next;
    end
  end

endmodule

>>> rtl/cqc_sum.sv
// ----------------------------------------------------------------------------
// cqc_sum
// Third stage: corner test, edge length, projection window, cross magnitude.
// ----------------------------------------------------------------------------
`include "circle_quad_collision_defines.svh"

module cqc_sum (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_stall,
  input  cqc_pkg::prod_t up_data,
  output logic           dn_valid,
  input  logic           dn_stall,
  output cqc_pkg::sum_t  dn_data
);
  import cqc_pkg::*;

  sum_t dn_data_next;
  logic stall_here;

  always_comb begin
    logic [LEN_W-1:0]        len;
    logic [LEN_W-1:0]        pq2;
    logic signed [SUM_W-1:0] dot;
    logic signed [SUM_W-1:0] crs;
    logic [SUM_W-1:0]        crs_abs;
    dn_data_next = '0;
    // corner strictly inside the circle
    for (int k = 0; k < 4; k++) begin
      len = up_data.dx2[k] + up_data.dy2[k];
      if (len < LEN_W'(up_data.r2)) begin
        dn_data_next.corner = 1'b1;
      end
    end
    // edge length, projection in [0, |pq|^2], cross magnitude
    for (int k = 0; k < 4; k++) begin
      pq2     = up_data.qx2[k] + up_data.qy2[k];
      dot     = SUM_W'($signed(up_data.dot_x[k])) + SUM_W'($signed(up_data.dot_y[k]));
      crs     = SUM_W'($signed(up_data.crs_a[k])) - SUM_W'($signed(up_data.crs_b[k]));
      crs_abs = crs[SUM_W-1] ? SUM_W'(-crs) : SUM_W'(crs);
      dn_data_next.pq2[k]     = pq2;
      dn_data_next.crs_mag[k] = crs_abs[LEN_W-1:0];
      dn_data_next.proj_ok[k] = (pq2 != '0) && !dot[SUM_W-1] &&
                                ($unsigned(dot) <= SUM_W'(pq2));
    end
    dn_data_next.r2 = up_data.r2;
  end

  // stage register
  assign stall_here = dn_valid && dn_stall;
  assign up_stall   = stall_here;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!stall_here) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_here && up_valid) begin
      dn_data <= dn_data_next;
    end
  end

  // a degenerate edge never opens the projection window
  `CQC_ASSERT(a_sum_degenerate, dn_valid |-> ((!dn_data.proj_ok[0] || dn_data.pq2[0] != '0) && (!dn_data.proj_ok[1] || dn_data.pq2[1] != '0) && (!dn_data.proj_ok[2] || dn_data.pq2[2] != '0) && (!dn_data.proj_ok[3] || dn_data.pq2[3] != '0)))
  // a stalled stage keeps its item
  `CQC_ASSERT(a_sum_hold, (dn_valid && dn_stall) |=> (dn_valid && $stable(dn_data)))

endmodule

>>> rtl/cqc_part.sv
// ----------------------------------------------------------------------------
// cqc_part
// Fourth stage: partial products of cross squared and r squared times |pq|^2.
// ----------------------------------------------------------------------------
`include "circle_quad_collision_defines.svh"

module cqc_part (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_stall,
  input  cqc_pkg::sum_t  up_data,
  output logic           dn_valid,
  input  logic           dn_stall,
  output cqc_pkg::part_t dn_data
);
  import cqc_pkg::*;

  part_t dn_data_next;
  logic  stall_here;

  // wide operands split in halves so each multiplier stays narrow
  always_comb begin
    logic [HALF_W-1:0] ch, cl, ph, pl;
    dn_data_next = '0;
    for (int k = 0; k < 4; k++) begin
      ch = up_data.crs_mag[k][LEN_W-1:HALF_W];
      cl = up_data.crs_mag[k][HALF_W-1:0];
      ph = up_data.pq2[k][LEN_W-1:HALF_W];
      pl = up_data.pq2[k][HALF_W-1:0];
      dn_data_next.sq_hh[k] = (2*HALF_W)'(ch) * (2*HALF_W)'(ch);
      dn_data_next.sq_hl[k] = (2*HALF_W)'(ch) * (2*HALF_W)'(cl);
      dn_data_next.sq_ll[k] = (2*HALF_W)'(cl) * (2*HALF_W)'(cl);
      dn_data_next.rp_h[k]  = RP_W'(up_data.r2) * RP_W'(ph);
      dn_data_next.rp_l[k]  = RP_W'(up_data.r2) * RP_W'(pl);
    end
    dn_data_next.corner  = up_data.corner;
    dn_data_next.proj_ok = up_data.proj_ok;
  end

  // stage register
  assign stall_here = dn_valid && dn_stall;
  assign up_stall   = stall_here;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!stall_here) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_here && up_valid) begin
      dn_data <= dn_data_next;
    end
  end

  // a stalled stage keeps its item
  `CQC_ASSERT(a_part_hold, (dn_valid && dn_stall) |=> (dn_valid && $stable(dn_data)))

endmodule

>>> rtl/cqc_cmp.sv
// ----------------------------------------------------------------------------
// cqc_cmp
// Last stage: recombine partial products, edge distance test, result flags.
// ----------------------------------------------------------------------------
module cqc_cmp (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_stall,
  input  cqc_pkg::part_t up_data,
  output logic           dn_valid,
  input  logic           dn_stall,
  output cqc_pkg::res_t  dn_data
);
  import cqc_pkg::*;

  res_t dn_data_next;
  logic stall_here;

  // cross^2 < r^2 * |pq|^2 on edges whose projection lands on them
  always_comb begin
    logic [SQ_W-1:0] sq;
    logic [SQ_W-1:0] rp;
    logic            edge_any;
    edge_any = 1'b0;
    for (int k = 0; k < 4; k++) begin
      sq = (SQ_W'(up_data.sq_hh[k]) << (2*HALF_W)) +
           (SQ_W'(up_data.sq_hl[k]) << (HALF_W+1)) +
           SQ_W'(up_data.sq_ll[k]);
      rp = (SQ_W'(up_data.rp_h[k]) << HALF_W) + SQ_W'(up_data.rp_l[k]);
      if (up_data.proj_ok[k] && (sq < rp)) begin
        edge_any = 1'b1;
      end
    end
    dn_data_next.corner_hit = up_data.corner;
    dn_data_next.edge_hit   = edge_any;
    dn_data_next.hit        = up_data.corner || edge_any;
  end

  // output register
  assign stall_here = dn_valid && dn_stall;
  assign up_stall   = stall_here;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!stall_here) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_here && up_valid) begin
      dn_data <= dn_data_next;
    end
  end

endmodule
